@@ design/etc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etc_pkg: shared constants and types for the epoch to calendar converter
// Reciprocal constants for the fixed divisions and the month start table.
// ----------------------------------------------------------------------------
package etc_pkg;

    // Number of pipeline register stages
    localparam int NSTG = 9;

    typedef logic [8:0] t_doy;

    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int DAYS_PER_QUAD = 1461;

    // days / 86400 = ((ts >> 7) / 675); floor reciprocal, at most one short
    localparam int             DAY_SHIFT = 35;
    localparam logic [25:0]    DAY_RECIP = 26'((64'd1 << DAY_SHIFT) / 64'd675);
    // (sod >> 4) / 225, exact for sod < 86400
    localparam int             HOUR_SHIFT = 20;
    localparam logic [12:0]    HOUR_RECIP = 13'(((1 << HOUR_SHIFT) + 224) / 225);
    // (rem >> 2) / 15, exact for rem < 3600
    localparam int             MIN_SHIFT = 14;
    localparam logic [10:0]    MIN_RECIP = 11'(((1 << MIN_SHIFT) + 14) / 15);
    // x / 7, exact for x < 65536
    localparam int             WDAY_SHIFT = 19;
    localparam logic [16:0]    WDAY_RECIP = 17'(((1 << WDAY_SHIFT) + 6) / 7);
    // x / 1461, exact for x < 65536
    localparam int             QUAD_SHIFT = 27;
    localparam logic [16:0]    QUAD_RECIP = 17'(((64'd1 << QUAD_SHIFT) + 64'd1460) / 64'd1461);

    // Day count from 1970-01-01 of 2100-03-01, the first day after the missing Feb 29
    localparam logic [15:0]    SKIP_DAY   = 16'd47541;
    // Days from 1968-01-01 to 1970-01-01
    localparam logic [15:0]    BASE_SHIFT = 16'd731;
    localparam logic [11:0]    BASE_YEAR  = 12'd1968;
    // Quad of four years that starts with 2100, counted from 1968
    localparam logic [5:0]     QUAD_2100  = 6'd33;

    // Day of year at which each month starts in a common year
    localparam t_doy MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    function automatic t_doy month_start(input logic [3:0] idx, input logic leap);
        t_doy base;
        base = MONTH_START[idx];
        if (leap && idx >= 4'd2) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage
`default_nettype wire

@@ design/etc_month.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// etc_month: month and day of month from day of year
// Compares the day of year against all month starts and subtracts the start.
// ----------------------------------------------------------------------------
module etc_month
    import etc_pkg::*;
(
    input  wire t_doy       i_doy,
    input  wire             i_leap,
    output logic [3:0]      o_month,
    output logic [4:0]      o_day_of_month
);

    logic [3:0] midx;
    t_doy       start;
    t_doy       dom;

    always_comb begin
        midx = 4'd0;
        // starts ascend, so the last one passed is the month
        for (int i = 1; i < 12; i++) begin
            if (i_doy >= month_start(4'(i), i_leap)) begin
                midx = 4'(i);
            end
        end
        start          = month_start(midx, i_leap);
        dom            = i_doy - start + 9'd1;
        o_month        = midx + 4'd1;
        o_day_of_month = dom[4:0];
    end

endmodule
`default_nettype wire

@@ design/epoch_to_calendar.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_to_calendar: Unix epoch seconds to Gregorian date and time
// Adds the time zone offset and breaks the time into calendar fields.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid with i_epoch_seconds; a transaction completes when
//   i_valid is high and o_stall is low. Output channel: o_valid with the
//   calendar fields; a transaction completes when o_valid is high and i_stall
//   is low. One result per input, in order.
//   The offset register (signed hours) is written through i_cfg_wr_en and
//   i_cfg_wr_data; write it only while the pipeline is empty, as the block
//   does not enforce this. Reset sets it to zero. Throughput, while i_stall
//   is low, is one transaction per cycle, set by a 9 stage pipeline whose
//   divisions are reciprocal multiplies, one multiplier per path per stage.
//   When the receiver stalls, the last stage holds its result and the stages
//   behind it keep filling bubbles; o_stall rises only once every stage is
//   full. o_stall never rises while i_stall is low.
//   Reset empties the pipeline; no result is in flight afterwards.
// ----------------------------------------------------------------------------
module epoch_to_calendar
    import etc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [4:0]  i_cfg_wr_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [8:0]  o_day_of_year,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [2:0]  o_weekday
);

    logic signed [4:0]  r_tz;
    logic [NSTG-1:0]    r_v;
    logic [NSTG-1:0]    stg_en;

    // stage registers
    logic [31:0] r0_ts;
    logic [31:0] r1_ts;
    logic [15:0] r1_q;
    logic [31:0] r2_ts;
    logic [31:0] r2_prod;
    logic [15:0] r2_q;
    logic [15:0] r3_days;
    logic [16:0] r3_sod;
    logic [15:0] r4_d;
    logic        r4_skip;
    logic [4:0]  r4_hour;
    logic [16:0] r4_sod;
    logic [15:0] r4_wx;
    logic [12:0] r4_wq;
    logic [15:0] r5_d;
    logic [5:0]  r5_quad;
    logic        r5_skip;
    logic [4:0]  r5_hour;
    logic [11:0] r5_remh;
    logic [2:0]  r5_wd;
    logic [10:0] r6_r;
    logic [5:0]  r6_quad;
    logic        r6_skip;
    logic [4:0]  r6_hour;
    logic [11:0] r6_remh;
    logic [5:0]  r6_min;
    logic [2:0]  r6_wd;
    logic [11:0] r7_year;
    t_doy        r7_doy;
    logic        r7_leap;
    logic [4:0]  r7_hour;
    logic [5:0]  r7_min;
    logic [5:0]  r7_sec;
    logic [2:0]  r7_wd;
    logic [11:0] r8_year;
    logic [3:0]  r8_month;
    logic [4:0]  r8_dom;
    t_doy        r8_doy;
    logic [4:0]  r8_hour;
    logic [5:0]  r8_min;
    logic [5:0]  r8_sec;
    logic [2:0]  r8_wd;

    // next values
    logic signed [17:0] n_tz_sec;
    logic signed [33:0] n_sum;
    logic [31:0]        n_ts;
    logic [50:0]        n_qprod;
    logic [31:0]        n_prod;
    logic [31:0]        n_rem;
    logic [15:0]        n_days;
    logic [16:0]        n_sod;
    logic               n_skip;
    logic [15:0]        n_d;
    logic [25:0]        n_hprod;
    logic [15:0]        n_wx;
    logic [32:0]        n_wprod;
    logic [32:0]        n_dprod;
    logic [16:0]        n_remh;
    logic [15:0]        n_wdiff;
    logic [15:0]        n_qd;
    logic [15:0]        n_r;
    logic [20:0]        n_mprod;
    logic [1:0]         n_yq;
    logic [10:0]        n_ybase;
    logic               n_is2100;
    t_doy               n_doy;
    logic [11:0]        n_year;
    logic [11:0]        n_secd;
    logic [3:0]         n_month;
    logic [4:0]         n_dom;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz <= '0;
        end else if (i_cfg_wr_en) begin
            r_tz <= i_cfg_wr_data;
        end
    end

    // a stage loads when it is empty or the stage after it moves on
    always_comb begin
        stg_en[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_v[k] || stg_en[k+1];
        end
    end

    assign o_stall = !stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: apply offset, saturate to the 32-bit range
    always_comb begin
        n_tz_sec = 18'(r_tz) * 18'sd3600;
        n_sum    = $signed({2'b00, i_epoch_seconds}) + 34'(n_tz_sec);
        if (n_sum[33]) begin
            n_ts = '0;
        end else if (n_sum[32]) begin
            n_ts = '1;
        end else begin
            n_ts = n_sum[31:0];
        end
    end

    // stage 1: estimate day count
    assign n_qprod = 51'(r0_ts[31:7]) * 51'(DAY_RECIP);

    // stage 2: product of estimate and day length
    assign n_prod = 32'(r1_q) * 32'(SECS_PER_DAY);

    // stage 3: remainder and one-step correction
    always_comb begin
        n_rem = r2_ts - r2_prod;
        if (n_rem >= 32'(SECS_PER_DAY)) begin
            n_days = r2_q + 16'd1;
            n_sod  = 17'(n_rem - 32'(SECS_PER_DAY));
        end else begin
            n_days = r2_q;
            n_sod  = n_rem[16:0];
        end
    end

    // stage 4: days from 1968, skipping the non-leap Feb 29 of 2100; hour and weekday quotients
    always_comb begin
        n_skip  = r3_days >= SKIP_DAY;
        n_d     = r3_days + BASE_SHIFT + {15'd0, n_skip};
        n_hprod = 26'(r3_sod[16:4]) * 26'(HOUR_RECIP);
        n_wx    = r3_days + 16'd4;
        n_wprod = 33'(n_wx) * 33'(WDAY_RECIP);
    end

    // stage 5: four-year cycle, remainder of hour, weekday
    always_comb begin
        n_dprod = 33'(r4_d) * 33'(QUAD_RECIP);
        n_remh  = r4_sod - 17'(17'(r4_hour) * 17'(SECS_PER_HOUR));
        n_wdiff = r4_wx - 16'(16'(r4_wq) * 16'd7);
    end

    // stage 6: day within the cycle, minute
    always_comb begin
        n_qd    = 16'(16'(r5_quad) * 16'(DAYS_PER_QUAD));
        n_r     = r5_d - n_qd;
        n_mprod = 21'(r5_remh[11:2]) * 21'(MIN_RECIP);
    end

    // stage 7: year within the cycle, day of year, second
    always_comb begin
        if (r6_r >= 11'd1096) begin
            n_yq    = 2'd3;
            n_ybase = 11'd1096;
        end else if (r6_r >= 11'd731) begin
            n_yq    = 2'd2;
            n_ybase = 11'd731;
        end else if (r6_r >= 11'd366) begin
            n_yq    = 2'd1;
            n_ybase = 11'd366;
        end else begin
            n_yq    = 2'd0;
            n_ybase = 11'd0;
        end
        n_is2100 = (r6_quad == QUAD_2100) && (n_yq == 2'd0);
        // drop the day inserted for the missing Feb 29 of 2100
        n_doy    = 9'(r6_r - n_ybase) - {8'd0, r6_skip && n_is2100};
        n_year   = BASE_YEAR + {4'd0, r6_quad, 2'b00} + {10'd0, n_yq};
        n_secd   = r6_remh - 12'(12'(r6_min) * 12'(SECS_PER_MIN));
    end

    // stage 8: month and day of month
    etc_month u_month (
        .i_doy          (r7_doy),
        .i_leap         (r7_leap),
        .o_month        (n_month),
        .o_day_of_month (n_dom)
    );

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r0_ts <= n_ts;
        end
        if (stg_en[1]) begin
            r1_ts <= r0_ts;
            r1_q  <= n_qprod[50:35];
        end
        if (stg_en[2]) begin
            r2_ts   <= r1_ts;
            r2_q    <= r1_q;
            r2_prod <= n_prod;
        end
        if (stg_en[3]) begin
            r3_days <= n_days;
            r3_sod  <= n_sod;
        end
        if (stg_en[4]) begin
            r4_d    <= n_d;
            r4_skip <= n_skip;
            r4_hour <= n_hprod[24:20];
            r4_sod  <= r3_sod;
            r4_wx   <= n_wx;
            r4_wq   <= n_wprod[31:19];
        end
        if (stg_en[5]) begin
            r5_d    <= r4_d;
            r5_quad <= n_dprod[32:27];
            r5_skip <= r4_skip;
            r5_hour <= r4_hour;
            r5_remh <= n_remh[11:0];
            r5_wd   <= n_wdiff[2:0];
        end
        if (stg_en[6]) begin
            r6_r    <= n_r[10:0];
            r6_quad <= r5_quad;
            r6_skip <= r5_skip;
            r6_hour <= r5_hour;
            r6_remh <= r5_remh;
            r6_min  <= n_mprod[19:14];
            r6_wd   <= r5_wd;
        end
        if (stg_en[7]) begin
            r7_year <= n_year;
            r7_doy  <= n_doy;
            r7_leap <= (n_yq == 2'd0) && (r6_quad != QUAD_2100);
            r7_hour <= r6_hour;
            r7_min  <= r6_min;
            r7_sec  <= n_secd[5:0];
            r7_wd   <= r6_wd;
        end
        if (stg_en[8]) begin
            r8_year  <= r7_year;
            r8_month <= n_month;
            r8_dom   <= n_dom;
            r8_doy   <= r7_doy;
            r8_hour  <= r7_hour;
            r8_min   <= r7_min;
            r8_sec   <= r7_sec;
            r8_wd    <= r7_wd;
        end
    end

    assign o_valid        = r_v[NSTG-1];
    assign o_year         = r8_year;
    assign o_month        = r8_month;
    assign o_day_of_month = r8_dom;
    assign o_day_of_year  = r8_doy;
    assign o_hour         = r8_hour;
    assign o_minute       = r8_min;
    assign o_second       = r8_sec;
    assign o_weekday      = r8_wd;

    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day_of_month >= 5'd1)
                    && (o_year >= 12'd1970) && (o_year <= 12'd2106))
        else $error("calendar date out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour < 5'd24) && (o_minute < 6'd60) && (o_second < 6'd60)
                    && (o_weekday < 3'd7))
        else $error("time of day out of range");

    a_january_doy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_month == 4'd1)) |-> (o_day_of_year == 9'(o_day_of_month) - 9'd1))
        else $error("day of year disagrees with January date");

endmodule
`default_nettype wire

@@ tb/epoch_to_calendar_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_to_calendar_tb: self-checking bench for the epoch to calendar converter
// Drives epoch stamps under several time zone offsets with random gaps and
// receiver stalls, and checks every calendar result against a local model.
// ----------------------------------------------------------------------------
module epoch_to_calendar_tb;

    localparam int LATENCY        = etc_pkg::NSTG;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DAY            = 86400;
    localparam int HOUR           = 3600;
    localparam int MINUTE         = 60;
    localparam int EPOCH_YEAR     = 1970;
    localparam int LAST_YEAR      = 2106;
    localparam int FEBRUARY       = 1;
    localparam int THURSDAY       = 4;
    localparam int RANDOM_PER_SET = 96;
    localparam int N_SETTINGS     = 9;
    localparam logic [31:0] TOP_STAMP = 32'hFFFF_FFFF;
    localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [8:0]  yday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
    } cal_t;

    typedef struct packed {
        logic [31:0] stamp;
        cal_t        cal;
    } stamp_cal_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [4:0]  i_cfg_wr_data = '0;
    logic        i_valid = 1'b0;
    logic [31:0] i_epoch_seconds = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;
    logic [8:0]  o_day_of_year;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic [2:0]  o_weekday;

    logic [31:0]       stamp_queue [$];
    stamp_cal_t        calendar_queue [$];
    logic signed [4:0] tz_hours = '0;
    int                err_count = 0;
    int                idle_cycles = 0;
    int                send_gap = 0;
    int                send_calm = 0;
    int                stall_left = 0;
    int                recv_calm = 0;

    epoch_to_calendar dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_day_of_year   (o_day_of_year),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .o_weekday       (o_weekday)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int year_len(input int unsigned yr);
        if (yr % 4 != 0) return 365;
        if (yr % 100 != 0) return 366;
        return (yr % 400 == 0) ? 366 : 365;
    endfunction

    function automatic int unsigned year_start_day(input int unsigned yr);
        int unsigned days;
        days = 0;
        for (int unsigned y = EPOCH_YEAR; y < yr; y++) begin
            days += year_len(y);
        end
        return days;
    endfunction

    // Saturate to the 32-bit stamp range
    function automatic logic [31:0] fit32(input longint t);
        if (t < 0) return '0;
        if (t > longint'(TOP_STAMP)) return TOP_STAMP;
        return t[31:0];
    endfunction

    function automatic cal_t to_calendar(input logic [31:0] secs, input logic signed [4:0] tz);
        int unsigned ts, days, sod, rest, yr, mon, mlen;
        logic        leap;
        cal_t        c;
        ts   = fit32(longint'(secs) + longint'(tz) * HOUR);
        days = ts / DAY;
        sod  = ts % DAY;
        yr   = EPOCH_YEAR;
        rest = days;
        while (rest >= year_len(yr)) begin
            rest -= year_len(yr);
            yr++;
        end
        leap   = (year_len(yr) == 366);
        c.yday = rest[8:0];
        mon    = 0;
        mlen   = MONTH_DAYS[0];
        while (mon < 11 && rest >= mlen) begin
            rest -= mlen;
            mon++;
            mlen = MONTH_DAYS[mon] + ((mon == FEBRUARY && leap) ? 1 : 0);
        end
        c.year   = 12'(yr);
        c.month  = 4'(mon + 1);
        c.mday   = 5'(rest + 1);
        c.hour   = 5'(sod / HOUR);
        c.minute = 6'((sod % HOUR) / MINUTE);
        c.second = 6'(sod % MINUTE);
        c.wday   = 3'((days + THURSDAY) % 7);
        return c;
    endfunction

    function automatic string cal_text(input cal_t c);
        return $sformatf("%0d-%0d-%0d yday %0d %0d:%0d:%0d wday %0d", c.year, c.month,
                         c.mday, c.yday, c.hour, c.minute, c.second, c.wday);
    endfunction

    // Mostly no gap, some short ones, a few long enough to fill the pipeline
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] random_stamp();
        int          r;
        int unsigned yr;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return $urandom;
        end else if (r < 55) begin
            // straddle a midnight
            return fit32(longint'($urandom_range(1, 49710)) * DAY + $urandom_range(0, 8) - 4);
        end else if (r < 70) begin
            // around a new year
            yr = $urandom_range(EPOCH_YEAR + 1, LAST_YEAR);
            return fit32(longint'(year_start_day(yr)) * DAY
                         + $urandom_range(0, 4 * DAY) - 2 * DAY);
        end else if (r < 82) begin
            // end of February through early March
            yr = $urandom_range(EPOCH_YEAR, LAST_YEAR - 1);
            return fit32(longint'(year_start_day(yr) + 58) * DAY + $urandom_range(0, 3 * DAY - 1));
        end else if (r < 91) begin
            return $urandom_range(0, 200000);
        end
        return TOP_STAMP - $urandom_range(0, 200000);
    endfunction

    // Driver: hold the transaction while stalled, otherwise advance
    always @(posedge i_clk) begin : drive
        stamp_cal_t entry;
        logic       fire;
        fire = i_valid && !o_stall;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (fire) begin
                entry.stamp = i_epoch_seconds;
                entry.cal   = to_calendar(i_epoch_seconds, tz_hours);
                calendar_queue.push_back(entry);
            end
            if (!i_valid || fire) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (stamp_queue.size() > 0) begin
                    i_valid         <= 1'b1;
                    i_epoch_seconds <= stamp_queue.pop_front();
                    if (send_calm > 0) begin
                        send_calm--;
                    end else begin
                        send_gap = pick_gap();
                        if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(20, 100);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random receiver stalls and result checking
    always @(posedge i_clk) begin : watch
        stamp_cal_t want;
        cal_t       got;
        logic       bad;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got.year   = o_year;
                got.month  = o_month;
                got.mday   = o_day_of_month;
                got.yday   = o_day_of_year;
                got.hour   = o_hour;
                got.minute = o_minute;
                got.second = o_second;
                got.wday   = o_weekday;
                if (calendar_queue.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result: %s", cal_text(got));
                end else begin
                    want = calendar_queue.pop_front();
                    bad  = (got.year !== want.cal.year) || (got.month !== want.cal.month)
                        || (got.mday !== want.cal.mday) || (got.yday !== want.cal.yday)
                        || (got.hour !== want.cal.hour) || (got.minute !== want.cal.minute)
                        || (got.second !== want.cal.second) || (got.wday !== want.cal.wday);
                    if (bad) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch stamp %0d: expected %s, actual %s",
                                     want.stamp, cal_text(want.cal), cal_text(got));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (recv_calm > 0) begin
                    recv_calm--;
                end else begin
                    stall_left = pick_gap();
                    if ($urandom_range(0, 29) == 0) recv_calm = $urandom_range(20, 100);
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("epoch_to_calendar verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (stamp_queue.size() != 0 || i_valid || calendar_queue.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_offset(input logic signed [4:0] tz);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= tz;
        tz_hours = tz;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Stamps where the shifted time just saturates or just escapes it
    task automatic push_offset_edges(input logic signed [4:0] tz);
        longint shift;
        shift = (tz < 0) ? -longint'(tz) * HOUR : longint'(tz) * HOUR;
        stamp_queue.push_back('0);
        stamp_queue.push_back(fit32(shift - 1));
        stamp_queue.push_back(fit32(shift));
        stamp_queue.push_back(fit32(shift + 1));
        stamp_queue.push_back(fit32(longint'(TOP_STAMP) - shift - 1));
        stamp_queue.push_back(fit32(longint'(TOP_STAMP) - shift));
        stamp_queue.push_back(TOP_STAMP);
    endtask

    initial begin
        logic signed [4:0] plan [N_SETTINGS];
        plan = '{5'sd0, -5'sd16, 5'sd15, -5'sd12, 5'sd14, -5'sd5, 5'sd9, 5'sd0, 5'sd0};
        plan[N_SETTINGS - 1] = 5'($urandom_range(0, 31));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < N_SETTINGS; p++) begin
            // the first set runs on the reset value of the offset
            if (p > 0) begin
                wait_drained();
                repeat (LATENCY + 3) @(posedge i_clk);
                write_offset(plan[p]);
            end
            if (p == 0) begin
                stamp_queue.push_back(32'd0);
                stamp_queue.push_back(32'd1);
                stamp_queue.push_back(32'd59);
                stamp_queue.push_back(32'd60);
                stamp_queue.push_back(32'd3599);
                stamp_queue.push_back(32'd3600);
                stamp_queue.push_back(32'd86399);
                stamp_queue.push_back(32'd86400);
                // last second of 1970 and first of 1971
                stamp_queue.push_back(fit32(365 * DAY - 1));
                stamp_queue.push_back(fit32(365 * DAY));
                // 1972-02-29, 1972-12-31 23:59:59
                stamp_queue.push_back(fit32(789 * DAY));
                stamp_queue.push_back(fit32(1095 * DAY + DAY - 1));
                // 2000-02-29 and 2000-12-31 noon, century leap year
                stamp_queue.push_back(fit32(11016 * DAY));
                stamp_queue.push_back(fit32(11322 * DAY + 12 * HOUR));
                // 2100 is not a leap year: Feb 28 is followed by Mar 1
                stamp_queue.push_back(fit32(longint'(47540) * DAY + DAY - 1));
                stamp_queue.push_back(fit32(longint'(47541) * DAY));
                stamp_queue.push_back(32'h7FFF_FFFF);
                stamp_queue.push_back(32'h8000_0000);
                stamp_queue.push_back(32'hAAAA_AAAA);
                stamp_queue.push_back(32'h5555_5555);
                stamp_queue.push_back(32'hFFFF_0000);
                stamp_queue.push_back(32'hFFFF_FFFE);
                stamp_queue.push_back(TOP_STAMP);
            end
            push_offset_edges(plan[p]);
            repeat (RANDOM_PER_SET) stamp_queue.push_back(random_stamp());
        end

        wait_drained();
        repeat (LATENCY + 5) @(posedge i_clk);
        if (err_count == 0) begin
            $display("epoch_to_calendar verification clean");
        end else begin
            $display("epoch_to_calendar verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/etc_pkg.sv
design/etc_month.sv
design/epoch_to_calendar.sv
tb/epoch_to_calendar_tb.sv
